/* hdl/dpt_pkg.sv */
package dpt_pkg;

    typedef struct packed {
        logic [30:0]        time_now;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } dpt_in_t;

    typedef struct packed {
        logic signed [31:0] lin_vel_cmd;
        logic signed [31:0] ang_vel_cmd;
    } dpt_out_t;

    localparam logic [2:0] CFG_DIST_KP = 3'd0;
    localparam logic [2:0] CFG_DIST_KI = 3'd1;
    localparam logic [2:0] CFG_DIST_KD = 3'd2;
    localparam logic [2:0] CFG_HEAD_KP = 3'd3;
    localparam logic [2:0] CFG_HEAD_KI = 3'd4;
    localparam logic [2:0] CFG_HEAD_KD = 3'd5;

    localparam int GAIN_FRAC = 8;
    localparam int ANG_FRAC  = 30;
    localparam int TAB_LEN   = 24;

    localparam logic signed [34:0] PI_Q30  = 35'sd3373259426;
    localparam logic signed [34:0] PI4_Q30 = 35'sd843314857;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd843314857;
            5'd1:  r = 32'd497837829;
            5'd2:  r = 32'd263043837;
            5'd3:  r = 32'd133525159;
            5'd4:  r = 32'd67021687;
            5'd5:  r = 32'd33543516;
            5'd6:  r = 32'd16775851;
            5'd7:  r = 32'd8388437;
            5'd8:  r = 32'd4194283;
            5'd9:  r = 32'd2097149;
            5'd10: r = 32'd1048576;
            5'd11: r = 32'd524288;
            5'd12: r = 32'd262144;
            5'd13: r = 32'd131072;
            5'd14: r = 32'd65536;
            5'd15: r = 32'd32768;
            5'd16: r = 32'd16384;
            5'd17: r = 32'd8192;
            5'd18: r = 32'd4096;
            5'd19: r = 32'd2048;
            5'd20: r = 32'd1024;
            5'd21: r = 32'd512;
            5'd22: r = 32'd256;
            5'd23: r = 32'd128;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* hdl/dpt_serial_mult.sv */
module dpt_serial_mult (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] a,
    input  logic signed [31:0] b,
    input  logic [5:0]         nbits,
    output logic               busy,
    output logic signed [65:0] p
);

    logic signed [65:0] a_sh_reg;
    logic [31:0]        b_sh_reg;
    logic [5:0]         cnt_reg;
    logic signed [65:0] acc_reg;
    logic signed [65:0] addend;
    logic signed [65:0] acc_next;

    // b taken one bit a cycle, LSB first; top bit carries negative weight
    always_comb begin
        addend = '0;
        if (b_sh_reg[0]) begin
            addend = (cnt_reg == 6'd1) ? -a_sh_reg : a_sh_reg;
        end
        acc_next = acc_reg + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg  <= nbits;
            a_sh_reg <= {{33{a[32]}}, a};
            b_sh_reg <= b;
            acc_reg  <= '0;
        end else if (cnt_reg != 6'd0) begin
            cnt_reg  <= cnt_reg - 6'd1;
            acc_reg  <= acc_next;
            a_sh_reg <= a_sh_reg <<< 1;
            b_sh_reg <= b_sh_reg >> 1;
        end
    end

    assign busy = (cnt_reg != 6'd0);
    assign p    = acc_reg;

endmodule

/* hdl/dpt_isqrt.sv */
module dpt_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] v,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] v_sh_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [33:0] rem_next;
    logic [31:0] root_next;

    // one result bit a cycle, two radicand bits consumed
    always_comb begin
        rem_sh = {rem_reg, v_sh_reg[63:62]};
        trial  = {2'b00, root_reg, 2'b01};
        if (rem_sh >= trial) begin
            rem_next  = 34'(rem_sh - trial);
            root_next = {root_reg[30:0], 1'b1};
        end else begin
            rem_next  = rem_sh[33:0];
            root_next = {root_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg  <= 6'd32;
            v_sh_reg <= v;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != 6'd0) begin
            cnt_reg  <= cnt_reg - 6'd1;
            v_sh_reg <= v_sh_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign busy = (cnt_reg != 6'd0);
    assign root = root_reg;

endmodule

/* hdl/dual_pid_pose_tracker_unit.sv */
// Work per request: 17 products on the shared bit-serial multiplier (16 or 32 bits each),
// two square roots and, unless the yaw is forced to zero, CORDIC pre-scaling and the
// CORDIC iterations. One request at a time: the next is taken once the result is in
// the output register, which waits while a held result has not yet been accepted.
// Synchronous active-low reset clears the gains, integrators, previous errors and
// handshake state.
module dual_pid_pose_tracker_unit #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  dpt_pkg::dpt_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output dpt_pkg::dpt_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import dpt_pkg::*;

    localparam int STEPS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int SH    = ANG_FRAC - FRAC_BITS;
    localparam logic signed [36:0] HALF   = 37'sd1 <<< (SH - 1);
    localparam logic signed [36:0] PI_W   = 37'(PI_Q30);
    localparam logic signed [36:0] TWO_PI = 37'(PI_Q30) <<< 1;
    localparam logic signed [47:0] NORM_LIMIT = 48'sd1099511627776;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MSET, ST_MRUN, ST_SQSET, ST_SQRUN,
        ST_ERR, ST_CNORM, ST_CITER, ST_HEAD, ST_FIN
    } state_t;

    typedef enum logic [4:0] {
        OP_TT, OP_XX, OP_YY, OP_QXX, OP_QYY, OP_QZZ, OP_QWW, OP_QXZ, OP_QWY,
        OP_QXY, OP_QWZ, OP_DP, OP_DI, OP_DD, OP_HP, OP_HI, OP_HD
    } op_t;

    state_t   state_reg;
    op_t      op_reg;
    logic     sq_sel_reg;
    dpt_in_t  in_reg;
    dpt_out_t out_reg;
    logic     m_valid_reg;

    logic signed [15:0] dkp_reg, dki_reg, dkd_reg, hkp_reg, hki_reg, hkd_reg;
    logic signed [31:0] dint_reg, hint_reg, dprev_reg, hprev_reg;

    logic [61:0]        sq_t_reg;
    logic [63:0]        sumsq_reg;
    logic [30:0]        d_reg;
    logic [29:0]        yz_reg;
    logic signed [31:0] m_reg, c_reg;
    logic [31:0]        mdes_reg, mcur_reg;
    logic signed [31:0] edist_reg, ehead_reg;
    logic signed [41:0] dp_reg, dd_reg, hp_reg, hd_reg;

    logic signed [47:0] x_reg, y_reg;
    logic signed [34:0] z_reg;
    logic [4:0]         i_reg;

    logic               mul_start, mul_busy;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic [5:0]         mul_n;
    logic signed [65:0] mul_p;
    logic signed [41:0] mul_term;

    logic        sq_start, sq_busy;
    logic [63:0] sq_v;
    logic [31:0] sq_root;

    logic signed [32:0] ed_diff, eh_diff;
    logic signed [47:0] m2, m2abs, d48, cy, cx;
    logic signed [47:0] ys, xs;
    logic signed [34:0] atan_s;
    logic signed [36:0] e_ang, e_wrap, e_rnd;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign mul_start = (state_reg == ST_MSET);
    assign sq_start  = (state_reg == ST_SQSET);
    assign sq_v      = sq_sel_reg ? sumsq_reg : {1'b0, sq_t_reg, 1'b0};
    assign mul_term  = 42'(mul_p >>> GAIN_FRAC);

    assign ed_diff = {edist_reg[31], edist_reg} - {dprev_reg[31], dprev_reg};
    assign eh_diff = {ehead_reg[31], ehead_reg} - {hprev_reg[31], hprev_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_n = 6'd16;
        case (op_reg)
            OP_TT: begin
                mul_a = {2'b00, in_reg.time_now};
                mul_b = {1'b0, in_reg.time_now};
                mul_n = 6'd32;
            end
            OP_XX: begin
                mul_a = {in_reg.pos_x[31], in_reg.pos_x};
                mul_b = in_reg.pos_x;
                mul_n = 6'd32;
            end
            OP_YY: begin
                mul_a = {in_reg.pos_y[31], in_reg.pos_y};
                mul_b = in_reg.pos_y;
                mul_n = 6'd32;
            end
            OP_QXX: begin
                mul_a = {{17{in_reg.quat_x[15]}}, in_reg.quat_x};
                mul_b = {{16{in_reg.quat_x[15]}}, in_reg.quat_x};
            end
            OP_QYY: begin
                mul_a = {{17{in_reg.quat_y[15]}}, in_reg.quat_y};
                mul_b = {{16{in_reg.quat_y[15]}}, in_reg.quat_y};
            end
            OP_QZZ: begin
                mul_a = {{17{in_reg.quat_z[15]}}, in_reg.quat_z};
                mul_b = {{16{in_reg.quat_z[15]}}, in_reg.quat_z};
            end
            OP_QWW: begin
                mul_a = {{17{in_reg.quat_w[15]}}, in_reg.quat_w};
                mul_b = {{16{in_reg.quat_w[15]}}, in_reg.quat_w};
            end
            OP_QXZ: begin
                mul_a = {{17{in_reg.quat_x[15]}}, in_reg.quat_x};
                mul_b = {{16{in_reg.quat_z[15]}}, in_reg.quat_z};
            end
            OP_QWY: begin
                mul_a = {{17{in_reg.quat_w[15]}}, in_reg.quat_w};
                mul_b = {{16{in_reg.quat_y[15]}}, in_reg.quat_y};
            end
            OP_QXY: begin
                mul_a = {{17{in_reg.quat_x[15]}}, in_reg.quat_x};
                mul_b = {{16{in_reg.quat_y[15]}}, in_reg.quat_y};
            end
            OP_QWZ: begin
                mul_a = {{17{in_reg.quat_w[15]}}, in_reg.quat_w};
                mul_b = {{16{in_reg.quat_z[15]}}, in_reg.quat_z};
            end
            OP_DP: begin
                mul_a = {edist_reg[31], edist_reg};
                mul_b = {{16{dkp_reg[15]}}, dkp_reg};
            end
            OP_DI: begin
                mul_a = {edist_reg[31], edist_reg};
                mul_b = {{16{dki_reg[15]}}, dki_reg};
            end
            OP_DD: begin
                mul_a = ed_diff;
                mul_b = {{16{dkd_reg[15]}}, dkd_reg};
            end
            OP_HP: begin
                mul_a = {ehead_reg[31], ehead_reg};
                mul_b = {{16{hkp_reg[15]}}, hkp_reg};
            end
            OP_HI: begin
                mul_a = {ehead_reg[31], ehead_reg};
                mul_b = {{16{hki_reg[15]}}, hki_reg};
            end
            OP_HD: begin
                mul_a = eh_diff;
                mul_b = {{16{hkd_reg[15]}}, hkd_reg};
            end
            default: begin
                mul_n = 6'd16;
            end
        endcase
    end

    // yaw set-up, CORDIC datapath and heading-error wrap and rounding
    always_comb begin
        m2     = 48'(m_reg) <<< 1;
        m2abs  = (m2 < 0) ? -m2 : m2;
        d48    = $signed({17'b0, d_reg});
        cy     = 48'(c_reg) <<< 1;
        cx     = d48 - $signed({17'b0, yz_reg, 1'b0});
        ys     = y_reg >>> i_reg;
        xs     = x_reg >>> i_reg;
        atan_s = $signed({3'b000, atan_entry(i_reg)});
        e_ang  = 37'(PI4_Q30) - 37'(z_reg);
        if (e_ang > PI_W) begin
            e_wrap = e_ang - TWO_PI;
        end else if (e_ang <= -PI_W) begin
            e_wrap = e_ang + TWO_PI;
        end else begin
            e_wrap = e_ang;
        end
        e_rnd = (e_wrap + HALF) >>> SH;
    end

    dpt_serial_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .nbits   (mul_n),
        .busy    (mul_busy),
        .p       (mul_p)
    );

    dpt_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .v       (sq_v),
        .busy    (sq_busy),
        .root    (sq_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_TT;
            sq_sel_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            dkp_reg     <= '0;
            dki_reg     <= '0;
            dkd_reg     <= '0;
            hkp_reg     <= '0;
            hki_reg     <= '0;
            hkd_reg     <= '0;
            dint_reg    <= '0;
            hint_reg    <= '0;
            dprev_reg   <= '0;
            hprev_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_DIST_KP: dkp_reg <= cfg_data;
                    CFG_DIST_KI: dki_reg <= cfg_data;
                    CFG_DIST_KD: dkd_reg <= cfg_data;
                    CFG_HEAD_KP: hkp_reg <= cfg_data;
                    CFG_HEAD_KI: hki_reg <= cfg_data;
                    CFG_HEAD_KD: hkd_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        op_reg    <= OP_TT;
                        state_reg <= ST_MSET;
                    end
                end
                ST_MSET: begin
                    state_reg <= ST_MRUN;
                end
                ST_MRUN: begin
                    if (!mul_busy) begin
                        case (op_reg)
                            OP_TT:  sq_t_reg  <= mul_p[61:0];
                            OP_XX:  sumsq_reg <= mul_p[63:0];
                            OP_YY:  sumsq_reg <= sumsq_reg + mul_p[63:0];
                            OP_QXX: d_reg     <= mul_p[30:0];
                            OP_QYY: begin
                                d_reg  <= d_reg + mul_p[30:0];
                                yz_reg <= mul_p[29:0];
                            end
                            OP_QZZ: begin
                                d_reg  <= d_reg + mul_p[30:0];
                                yz_reg <= yz_reg + mul_p[29:0];
                            end
                            OP_QWW: d_reg <= d_reg + mul_p[30:0];
                            OP_QXZ: m_reg <= mul_p[31:0];
                            OP_QWY: m_reg <= m_reg - mul_p[31:0];
                            OP_QXY: c_reg <= mul_p[31:0];
                            OP_QWZ: c_reg <= c_reg + mul_p[31:0];
                            OP_DP:  dp_reg <= mul_term;
                            OP_DI:  dint_reg <= sat32(48'(dint_reg) + 48'(mul_term));
                            OP_DD:  dd_reg <= mul_term;
                            OP_HP:  hp_reg <= mul_term;
                            OP_HI:  hint_reg <= sat32(48'(hint_reg) + 48'(mul_term));
                            OP_HD:  hd_reg <= mul_term;
                            default: ;
                        endcase
                        if (op_reg == OP_QWZ) begin
                            sq_sel_reg <= 1'b0;
                            state_reg  <= ST_SQSET;
                        end else if (op_reg == OP_HD) begin
                            state_reg <= ST_FIN;
                        end else begin
                            op_reg    <= op_t'(op_reg + 5'd1);
                            state_reg <= ST_MSET;
                        end
                    end
                end
                ST_SQSET: begin
                    state_reg <= ST_SQRUN;
                end
                ST_SQRUN: begin
                    if (!sq_busy) begin
                        if (!sq_sel_reg) begin
                            mdes_reg   <= sq_root;
                            sq_sel_reg <= 1'b1;
                            state_reg  <= ST_SQSET;
                        end else begin
                            mcur_reg  <= sq_root;
                            state_reg <= ST_ERR;
                        end
                    end
                end
                ST_ERR: begin
                    edist_reg <= sat32($signed({16'b0, mdes_reg})
                                       - $signed({16'b0, mcur_reg}));
                    // degenerate quaternion, gimbal lock or zero vector: yaw 0
                    if (d_reg == 31'd0 || m2abs >= d48 || (cx == 0 && cy == 0)) begin
                        z_reg     <= '0;
                        state_reg <= ST_HEAD;
                    end else if (cx < 0) begin
                        z_reg     <= (cy >= 0) ? PI_Q30 : -PI_Q30;
                        x_reg     <= -cx;
                        y_reg     <= -cy;
                        state_reg <= ST_CNORM;
                    end else begin
                        z_reg     <= '0;
                        x_reg     <= cx;
                        y_reg     <= cy;
                        state_reg <= ST_CNORM;
                    end
                end
                ST_CNORM: begin
                    if (x_reg < NORM_LIMIT && x_reg > -NORM_LIMIT &&
                        y_reg < NORM_LIMIT && y_reg > -NORM_LIMIT) begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= ST_CITER;
                    end
                end
                ST_CITER: begin
                    if (y_reg > 0) begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_s;
                    end else begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_s;
                    end
                    if (i_reg == 5'(STEPS - 1)) begin
                        state_reg <= ST_HEAD;
                    end else begin
                        i_reg <= i_reg + 5'd1;
                    end
                end
                ST_HEAD: begin
                    ehead_reg <= sat32(48'(e_rnd));
                    op_reg    <= OP_DP;
                    state_reg <= ST_MSET;
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.lin_vel_cmd <= sat32(48'(dp_reg) + 48'(dint_reg)
                                                     + 48'(dd_reg));
                        out_reg.ang_vel_cmd <= sat32(48'(hp_reg) + 48'(hint_reg)
                                                     + 48'(hd_reg));
                        dprev_reg   <= edist_reg;
                        hprev_reg   <= ehead_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/dpt_checker.sv */
module dpt_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input dpt_pkg::dpt_out_t m_data,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    a_reset_no_result: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_cfg_always_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind dual_pid_pose_tracker_unit dpt_checker u_dpt_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
